@@ rtl/rbm_pkg.sv @@
// ----------------------------------------------------------------------------
// rbm_pkg: shared definitions for the RGB box mean filter
// Register indexes, reset values, input kind, back-end states, queue depth.
// ----------------------------------------------------------------------------
package rbm_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [10:0] WIDTH_RST  = 11'd1024;
    localparam logic [12:0] HEIGHT_RST = 13'd1;
    localparam logic [1:0]  RADIUS_RST = 2'd2;

    // Input kind carried in tuser.
    localparam logic OP_PIXEL = 1'b0;

    // Entries in the queue between the front and the back end.
    localparam int QDEPTH = 2;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_LAST,
        B_DIV,
        B_OUT
    } back_state_t;

endpackage

@@ rtl/rbm_fifo.sv @@
// ----------------------------------------------------------------------------
// rbm_fifo: short job queue
// Holds output jobs between the front end and the back end.
// ----------------------------------------------------------------------------
module rbm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [PW:0]      cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rp_reg];

    // Storage is written at the tail only.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("job queue underflow");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> !empty) else $error("job queue count lost a push");
`endif

endmodule

@@ rtl/rbm_front.sv @@
// ----------------------------------------------------------------------------
// rbm_front: input tracking and output scheduling
// Writes pixels into the line store, tracks input and output positions and
// queues an output job once the last pixel of its window has arrived.
// ----------------------------------------------------------------------------
module rbm_front #(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int RING = MAX_WINDOW + 1,
    localparam int RW   = $clog2(MAX_HEIGHT),
    localparam int CW   = $clog2(MAX_WIDTH),
    localparam int SW   = $clog2(RING),
    localparam int AW   = $clog2(RING * MAX_WIDTH),
    localparam int JW   = 1 + RW + SW + CW + 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          restart,
    input  logic [10:0]   cfg_width,
    input  logic [12:0]   cfg_height,
    input  logic [1:0]    cfg_radius,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_op,
    input  logic [23:0]   s_pixel,
    output logic          job_push,
    output logic [JW-1:0] job_data,
    input  logic          q_full,
    input  logic          q_empty,
    input  logic [JW-1:0] q_head,
    input  logic          back_busy,
    input  logic [JW-1:0] back_job,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output logic [23:0]   wr_data
);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RCAP = (MAX_WINDOW - 1) / 2;

    typedef struct packed {
        logic          last;
        logic [RW-1:0] r_beg;
        logic [SW-1:0] slot;
        logic [CW-1:0] c_beg;
        logic [2:0]    r_cnt;
        logic [2:0]    c_cnt;
    } job_t;

    logic [RW-1:0] in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [CW-1:0] in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [SW-1:0] in_slot_reg, in_slot_next, out_slot_reg, out_slot_next;
    logic          in_full_reg, in_full_next;
    logic          flush_reg, flush_next;

    logic [WW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic [1:0]    rad;
    logic          accept, due, pend, safe;
    logic [RW-1:0] oldest;
    logic [HW-1:0] r_sum, r_end, r_beg;
    logic [WW-1:0] c_sum, c_end, c_beg;
    logic [1:0]    k;
    job_t          job, head_job, cur_job;

    // Effective frame geometry and radius after clamping.
    always_comb begin
        if (cfg_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(cfg_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(cfg_width);
        end
        if (cfg_height == '0) begin
            eff_h = HW'(1);
        end else if (32'(cfg_height) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(cfg_height);
        end
        rad = (32'(cfg_radius) > RCAP) ? 2'(RCAP) : cfg_radius;
    end

    // Hold off pixels that would overwrite a row a pending job still reads.
    // Jobs left over from the previous frame use row numbers of that frame,
    // so the next frame waits until they have all left.
    always_comb begin
        head_job = job_t'(q_head);
        cur_job  = job_t'(back_job);
        oldest   = back_busy ? cur_job.r_beg : head_job.r_beg;
        pend     = back_busy || !q_empty;
        safe     = !pend ||
                   (!flush_reg &&
                    (({1'b0, in_row_reg} + (RW+1)'(rad)) < ({1'b0, oldest} + (RW+1)'(RING))));
        s_ready  = !q_full && safe;
        accept   = s_valid && s_ready;
    end

    // Line store write for the accepted pixel.
    assign wr_en   = accept && (s_op == rbm_pkg::OP_PIXEL) && !in_full_reg;
    assign wr_addr = AW'(32'(in_slot_reg) * MAX_WIDTH + 32'(in_col_reg));
    assign wr_data = s_pixel;

    // Input position, window bounds of the next output, and its scheduling.
    always_comb begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_slot_next  = in_slot_reg;
        in_full_next  = in_full_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;

        if (wr_en) begin
            if (({1'b0, in_col_reg} + 1'b1) >= (CW+1)'(eff_w)) begin
                in_col_next = '0;
                if ((HW'(in_row_reg) + 1'b1) >= eff_h) begin
                    in_row_next  = '0;
                    in_slot_next = '0;
                    in_full_next = 1'b1;
                end else begin
                    in_row_next  = in_row_reg + 1'b1;
                    in_slot_next = (in_slot_reg == SW'(RING-1)) ? '0 : in_slot_reg + 1'b1;
                end
            end else begin
                in_col_next = in_col_reg + 1'b1;
            end
        end

        r_sum = HW'(out_row_reg) + HW'(rad);
        r_end = (r_sum > eff_h - 1'b1) ? eff_h - 1'b1 : r_sum;
        c_sum = WW'(out_col_reg) + WW'(rad);
        c_end = (c_sum > eff_w - 1'b1) ? eff_w - 1'b1 : c_sum;
        r_beg = (HW'(out_row_reg) >= HW'(rad)) ? HW'(out_row_reg) - HW'(rad) : '0;
        c_beg = (WW'(out_col_reg) >= WW'(rad)) ? WW'(out_col_reg) - WW'(rad) : '0;
        k     = (HW'(out_row_reg) >= HW'(rad)) ? rad : 2'(out_row_reg);

        job.r_beg = RW'(r_beg);
        job.c_beg = CW'(c_beg);
        job.r_cnt = 3'(r_end - r_beg);
        job.c_cnt = 3'(c_end - c_beg);
        job.slot  = (out_slot_reg >= SW'(k)) ? out_slot_reg - SW'(k)
                                             : out_slot_reg + SW'(RING) - SW'(k);
        job.last  = 1'b0;

        due = in_full_next || (r_end < HW'(in_row_next)) ||
              ((r_end == HW'(in_row_next)) && (c_end < WW'(in_col_next)));
        job_push = accept && due;

        if (job_push) begin
            if ((WW'(out_col_reg) + 1'b1) >= eff_w) begin
                out_col_next = '0;
                if ((HW'(out_row_reg) + 1'b1) >= eff_h) begin
                    out_row_next  = '0;
                    out_slot_next = '0;
                    in_full_next  = 1'b0;
                    job.last      = 1'b1;
                end else begin
                    out_row_next  = out_row_reg + 1'b1;
                    out_slot_next = (out_slot_reg == SW'(RING-1)) ? '0 : out_slot_reg + 1'b1;
                end
            end else begin
                out_col_next = out_col_reg + 1'b1;
            end
        end
        job_data = JW'(job);

        // Frame change: set when the last job of a frame is queued, cleared
        // once no job is pending.
        if (job_push && job.last) begin
            flush_next = 1'b1;
        end else if (!pend) begin
            flush_next = 1'b0;
        end else begin
            flush_next = flush_reg;
        end
    end

    // Position registers; a register write restarts the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            in_full_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
            flush_reg    <= 1'b0;
        end else begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            in_full_reg  <= in_full_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
            flush_reg    <= flush_next;
        end
    end

endmodule

@@ rtl/rbm_back.sv @@
// ----------------------------------------------------------------------------
// rbm_back: window summing and division
// Owns the line store, sums the window of one job a pixel per cycle, divides
// the three channel sums by the window size and holds the result.
// ----------------------------------------------------------------------------
module rbm_back #(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    localparam int RING = MAX_WINDOW + 1,
    localparam int RW   = $clog2(MAX_HEIGHT),
    localparam int CW   = $clog2(MAX_WIDTH),
    localparam int SW   = $clog2(RING),
    localparam int AW   = $clog2(RING * MAX_WIDTH),
    localparam int JW   = 1 + RW + SW + CW + 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          job_vld,
    output logic          job_pop,
    input  logic [JW-1:0] job_in,
    output logic          busy,
    output logic [JW-1:0] cur_job,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [23:0]   m_pixel,
    output logic          m_last
);
    localparam int SMW  = $clog2(MAX_WINDOW * MAX_WINDOW * 255 + 1);
    localparam int CNTW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int DVW  = SMW + 8;

    typedef struct packed {
        logic          last;
        logic [RW-1:0] r_beg;
        logic [SW-1:0] slot;
        logic [CW-1:0] c_beg;
        logic [2:0]    r_cnt;
        logic [2:0]    c_cnt;
    } job_t;

    rbm_pkg::back_state_t state_reg, state_next;

    logic [23:0]     mem [RING * MAX_WIDTH];
    logic [23:0]     rd_data_reg;
    logic            rd_vld_reg;
    logic [AW-1:0]   rd_addr;
    job_t            job_reg, job_new;
    logic [SW-1:0]   slot_reg;
    logic [CW-1:0]   col_reg;
    logic [2:0]      r_left_reg, c_left_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [SMW-1:0]  sum_reg [3];
    logic [7:0]      q_reg [3];
    logic [2:0]      step_reg;
    logic            last_issue;
    logic [DVW-1:0]  cmp;

    assign job_new    = job_t'(job_in);
    assign busy       = (state_reg != rbm_pkg::B_IDLE);
    assign cur_job    = JW'(job_reg);
    assign rd_addr    = AW'(32'(slot_reg) * MAX_WIDTH + 32'(col_reg));
    assign last_issue = (r_left_reg == '0) && (c_left_reg == '0);
    assign cmp        = DVW'(cnt_reg) << step_reg;
    assign m_pixel    = {q_reg[2], q_reg[1], q_reg[0]};
    assign m_last     = job_reg.last;

    // Line store: one write port from the front end, one registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rbm_pkg::B_IDLE: if (job_vld) state_next = rbm_pkg::B_READ;
            rbm_pkg::B_READ: if (last_issue) state_next = rbm_pkg::B_LAST;
            rbm_pkg::B_LAST: state_next = rbm_pkg::B_DIV;
            rbm_pkg::B_DIV:  if (step_reg == '0) state_next = rbm_pkg::B_OUT;
            rbm_pkg::B_OUT:  if (m_ready) state_next = rbm_pkg::B_IDLE;
            default:         state_next = rbm_pkg::B_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        job_pop = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            rbm_pkg::B_IDLE: job_pop = job_vld;
            rbm_pkg::B_OUT:  m_valid = 1'b1;
            default: begin
                job_pop = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= rbm_pkg::B_IDLE;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == rbm_pkg::B_READ);
        end
    end

    // Window walk, accumulation and restoring division on the sums.
    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg    <= job_new;
            slot_reg   <= job_new.slot;
            col_reg    <= job_new.c_beg;
            r_left_reg <= job_new.r_cnt;
            c_left_reg <= job_new.c_cnt;
            cnt_reg    <= CNTW'((6'(job_new.r_cnt) + 6'd1) * (6'(job_new.c_cnt) + 6'd1));
            step_reg   <= 3'd7;
            for (int i = 0; i < 3; i++) begin
                sum_reg[i] <= '0;
                q_reg[i]   <= '0;
            end
        end else begin
            if (state_reg == rbm_pkg::B_READ && !last_issue) begin
                if (c_left_reg == '0) begin
                    r_left_reg <= r_left_reg - 1'b1;
                    c_left_reg <= job_reg.c_cnt;
                    col_reg    <= job_reg.c_beg;
                    slot_reg   <= (slot_reg == SW'(RING-1)) ? '0 : slot_reg + 1'b1;
                end else begin
                    c_left_reg <= c_left_reg - 1'b1;
                    col_reg    <= col_reg + 1'b1;
                end
            end
            if (rd_vld_reg) begin
                for (int i = 0; i < 3; i++) begin
                    sum_reg[i] <= sum_reg[i] + SMW'(rd_data_reg[8*i +: 8]);
                end
            end
            if (state_reg == rbm_pkg::B_DIV) begin
                step_reg <= step_reg - 1'b1;
                for (int i = 0; i < 3; i++) begin
                    if (DVW'(sum_reg[i]) >= cmp) begin
                        sum_reg[i]         <= SMW'(DVW'(sum_reg[i]) - cmp);
                        q_reg[i][step_reg] <= 1'b1;
                    end
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbm_pkg::B_DIV && step_reg == '0) |=> (state_reg == rbm_pkg::B_OUT))
        else $error("division did not end in the output state");
    a_rd_src: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> ($past(state_reg) == rbm_pkg::B_READ))
        else $error("read data flagged without a read");
    a_last_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbm_pkg::B_LAST) |-> rd_vld_reg)
        else $error("final window pixel not accumulated");
`endif

endmodule

@@ rtl/rgb_box_mean_filter.sv @@
// ----------------------------------------------------------------------------
// rgb_box_mean_filter: streaming RGB box mean filter
// Per-channel mean over a square window around each pixel of a frame.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ stream in raster order, tdata holding the packed
// pixel and tuser the kind (0 pixel, 1 drain tick). Each output request on
// the m_ stream carries the averaged pixel, with tlast on the last pixel of
// the frame. Drain ticks after the last pixel flush the trailing outputs.
// Frame width, height and radius are set through the APB port; the user
// must write them only while idle, which the block does not enforce; any
// register write restarts the frame. An output takes its job from the
// queue, makes one line store read per window pixel inside the frame,
// closes the sum, runs a bit-serial division and presents the result.
// The back end works on one output at a time and takes the next job only
// once the result has been accepted. The single read port of the line store
// and the bit-serial divider set the pace of outputs. A short job queue lets
// inputs run ahead while the output waits; inputs stall when that queue is
// full, when a pixel would overwrite a row still being read, and after the
// last job of a frame until all of that frame's outputs have left.
// Reset clears positions and control; the line store is not cleared. When
// the receiver stalls, the result holds and inputs back up into the queue.
// ----------------------------------------------------------------------------
module rgb_box_mean_filter #(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] in_pixel
    input  logic [0:0]  s_tuser,   // [0] operation
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [23:0] out_pixel
    output logic        m_tlast
);
    localparam int RING = MAX_WINDOW + 1;
    localparam int RW   = $clog2(MAX_HEIGHT);
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int SW   = $clog2(RING);
    localparam int AW   = $clog2(RING * MAX_WIDTH);
    localparam int JW   = 1 + RW + SW + CW + 6;

    logic [10:0]   width_reg;
    logic [12:0]   height_reg;
    logic [1:0]    radius_reg;
    logic          cfg_wr, restart;
    logic          job_push, job_pop, q_full, q_empty, back_busy;
    logic [JW-1:0] job_data, q_head, back_job;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [23:0]   wr_data;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign restart = cfg_wr && (paddr[3:2] == rbm_pkg::REG_WIDTH ||
                                paddr[3:2] == rbm_pkg::REG_HEIGHT ||
                                paddr[3:2] == rbm_pkg::REG_RADIUS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rbm_pkg::WIDTH_RST;
            height_reg <= rbm_pkg::HEIGHT_RST;
            radius_reg <= rbm_pkg::RADIUS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                rbm_pkg::REG_WIDTH:  width_reg  <= pwdata[10:0];
                rbm_pkg::REG_HEIGHT: height_reg <= pwdata[12:0];
                rbm_pkg::REG_RADIUS: radius_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[3:2])
            rbm_pkg::REG_WIDTH:  prdata = {21'd0, width_reg};
            rbm_pkg::REG_HEIGHT: prdata = {19'd0, height_reg};
            rbm_pkg::REG_RADIUS: prdata = {30'd0, radius_reg};
            default:             prdata = '0;
        endcase
    end

    rbm_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .restart    (restart),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .cfg_radius (radius_reg),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_op       (s_tuser[0]),
        .s_pixel    (s_tdata),
        .job_push   (job_push),
        .job_data   (job_data),
        .q_full     (q_full),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .back_busy  (back_busy),
        .back_job   (back_job),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    rbm_fifo #(
        .WIDTH (JW),
        .DEPTH (rbm_pkg::QDEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (job_data),
        .pop       (job_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    rbm_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .job_vld  (!q_empty),
        .job_pop  (job_pop),
        .job_in   (q_head),
        .busy     (back_busy),
        .cur_job  (back_job),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_pixel  (m_tdata),
        .m_last   (m_tlast)
    );

endmodule
